// ===== hdl/nhl_pkg.sv =====
// ----------------------------------------------------------------------------
// nhl_pkg: shared definitions for the neighbor handshake liveness block
// Field widths, command, handshake and action codes, register indexes.
// ----------------------------------------------------------------------------
package nhl_pkg;

    localparam int ID_BITS_DEF    = 8;
    localparam int TIMER_BITS_DEF = 16;

    localparam int CMD_W      = 1;
    localparam int HS_W       = 2;
    localparam int ACT_W      = 3;
    localparam int MAX_RES    = 4;
    localparam int SLOT_W     = 2;
    localparam int RES_CNT_W  = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_TIME_W = 16;

    localparam logic [CFG_TIME_W-1:0] DEFAULT_TIME = 16'd1500;

    typedef logic [ACT_W-1:0]     t_action;
    typedef logic [HS_W-1:0]      t_hs;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MSG  = 1'b1;

    localparam t_hs HS_PING_M2S = 2'd0;
    localparam t_hs HS_ACK_M2S  = 2'd1;
    localparam t_hs HS_PING_S2M = 2'd2;
    localparam t_hs HS_ACK_S2M  = 2'd3;

    localparam t_action ACT_SEND_SLAVE   = 3'd0;
    localparam t_action ACT_SEND_MASTER  = 3'd1;
    localparam t_action ACT_FLUSH_SLAVE  = 3'd2;
    localparam t_action ACT_FLUSH_MASTER = 3'd3;
    localparam t_action ACT_REPORT_MSTR  = 3'd4;
    localparam t_action ACT_REPORT_LOCAL = 3'd5;

    localparam t_cfg_idx CFG_SELF_ID     = 2'd0;
    localparam t_cfg_idx CFG_ROOT_ID     = 2'd1;
    localparam t_cfg_idx CFG_ACK_TIMEOUT = 2'd2;
    localparam t_cfg_idx CFG_PING_PERIOD = 2'd3;

    function automatic int res_w(input int id_bits);
        return ACT_W + HS_W + 3 * id_bits;
    endfunction

    function automatic int bundle_w(input int id_bits);
        return RES_CNT_W + MAX_RES * res_w(id_bits);
    endfunction

endpackage

// ===== hdl/nhl_queue.sv =====
// ----------------------------------------------------------------------------
// nhl_queue: short register FIFO of result bundles
// Decouples the event front end from the result serializer.
// ----------------------------------------------------------------------------
module nhl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/nhl_front.sv =====
// ----------------------------------------------------------------------------
// nhl_front: event front end
// Holds configuration and neighbor state, classifies each event and builds
// the ordered bundle of results it causes.
// ----------------------------------------------------------------------------
module nhl_front #(
    parameter int ID_BITS    = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [nhl_pkg::CFG_IDX_W-1:0]             i_cfg_idx,
    input  logic [nhl_pkg::CFG_DATA_W-1:0]            i_cfg_wdata,
    input  logic                                      i_valid,
    input  logic                                      i_cmd,
    input  logic [nhl_pkg::HS_W-1:0]                  i_hs,
    input  logic signed [ID_BITS-1:0]                 i_sender,
    output logic                                      o_ready,
    input  logic                                      i_q_full,
    output logic                                      o_push,
    output logic [nhl_pkg::bundle_w(ID_BITS)-1:0]     o_bundle
);
    import nhl_pkg::*;

    localparam int RES_W = res_w(ID_BITS);
    localparam logic signed [ID_BITS-1:0] ID_UNK = '1;

    logic signed [ID_BITS-1:0]  r_self, r_root;
    logic [CFG_TIME_W-1:0]      r_ack_to, r_per;

    logic signed [ID_BITS-1:0]  r_m_now, n_m_now, r_s_now, n_s_now;
    logic signed [ID_BITS-1:0]  r_m_at, n_m_at, r_s_at, n_s_at;
    logic                       r_m_wait, n_m_wait, r_s_wait, n_s_wait;
    logic [TIMER_BITS-1:0]      r_m_tmr, n_m_tmr, r_s_tmr, n_s_tmr;

    logic [TIMER_BITS-1:0]      win, per, rem_to, a_tmr, spent, rem_ack, s_t1, m_t1;
    logic                       accept, m_active;

    logic                       f_a, f_b, f_c, f_d, f_e, rep_en;
    t_action                    a_act, b_act, rep_act;
    t_hs                        a_hs;
    logic signed [ID_BITS-1:0]  rep_m, rep_s;

    logic [RES_CNT_W-1:0]       cnt;
    t_action                    s_act [MAX_RES];
    t_hs                        s_hs  [MAX_RES];
    logic signed [ID_BITS-1:0]  s_rs  [MAX_RES];
    logic signed [ID_BITS-1:0]  s_rm  [MAX_RES];
    logic signed [ID_BITS-1:0]  s_rl  [MAX_RES];

    // saturate timing registers to the timer range
    if (TIMER_BITS >= CFG_TIME_W) begin : g_tm_wide
        assign win = TIMER_BITS'(r_ack_to);
        assign per = TIMER_BITS'(r_per);
    end else begin : g_tm_narrow
        assign win = (|r_ack_to[CFG_TIME_W-1:TIMER_BITS]) ? '1 : r_ack_to[TIMER_BITS-1:0];
        assign per = (|r_per[CFG_TIME_W-1:TIMER_BITS]) ? '1 : r_per[TIMER_BITS-1:0];
    end

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign m_active = (r_self != r_root);

    assign rem_to  = (per > win) ? per - win : '0;
    assign a_tmr   = (i_hs == HS_ACK_M2S) ? r_s_tmr : r_m_tmr;
    assign spent   = (win > a_tmr) ? win - a_tmr : '0;
    assign rem_ack = (per > spent) ? per - spent : '0;
    assign s_t1    = (r_s_tmr != '0) ? r_s_tmr - TIMER_BITS'(1) : '0;
    assign m_t1    = (r_m_tmr != '0) ? r_m_tmr - TIMER_BITS'(1) : '0;

    always_comb begin
        n_m_now  = r_m_now;
        n_s_now  = r_s_now;
        n_m_at   = r_m_at;
        n_s_at   = r_s_at;
        n_m_wait = r_m_wait;
        n_s_wait = r_s_wait;
        n_m_tmr  = r_m_tmr;
        n_s_tmr  = r_s_tmr;
        f_a      = 1'b0;
        f_b      = 1'b0;
        f_c      = 1'b0;
        f_d      = 1'b0;
        f_e      = 1'b0;
        a_act    = ACT_SEND_MASTER;
        a_hs     = HS_ACK_M2S;
        b_act    = ACT_FLUSH_SLAVE;
        rep_m    = r_m_now;
        rep_s    = r_s_now;
        if (accept) begin
            if (i_cmd == CMD_TICK) begin
                if (s_t1 != '0) begin
                    n_s_tmr = s_t1;
                end else if (r_s_wait) begin
                    if (r_s_at != ID_UNK) begin
                        n_s_now = ID_UNK;
                        f_c     = 1'b1;
                    end
                    n_s_wait = 1'b0;
                    n_s_tmr  = rem_to;
                    f_d      = (rem_to == '0);
                end else begin
                    f_d = 1'b1;
                end
                if (m_active) begin
                    if (m_t1 != '0) begin
                        n_m_tmr = m_t1;
                    end else if (r_m_wait) begin
                        if (r_m_at != ID_UNK) begin
                            n_m_now = ID_UNK;
                        end
                        n_m_wait = 1'b0;
                        n_m_tmr  = rem_to;
                        f_e      = (rem_to == '0);
                    end else begin
                        f_e = 1'b1;
                    end
                end
                // slave loss is reported before the master side moves
                rep_m = r_m_now;
                rep_s = n_s_now;
            end else begin
                case (i_hs)
                    HS_PING_M2S: begin
                        f_a   = 1'b1;
                        a_act = ACT_SEND_MASTER;
                        a_hs  = HS_ACK_M2S;
                        if (i_sender != r_m_now) begin
                            n_m_now = i_sender;
                            f_b     = 1'b1;
                            b_act   = ACT_FLUSH_MASTER;
                            f_c     = 1'b1;
                        end
                    end
                    HS_ACK_M2S: begin
                        if (r_s_wait) begin
                            if (i_sender != r_s_now) begin
                                n_s_now = i_sender;
                                f_b     = 1'b1;
                                b_act   = ACT_FLUSH_SLAVE;
                                f_c     = 1'b1;
                            end
                            n_s_wait = 1'b0;
                            n_s_tmr  = rem_ack;
                            f_d      = (rem_ack == '0);
                        end
                    end
                    HS_PING_S2M: begin
                        f_a   = 1'b1;
                        a_act = ACT_SEND_SLAVE;
                        a_hs  = HS_ACK_S2M;
                        if (i_sender != r_s_now) begin
                            n_s_now = i_sender;
                            f_b     = 1'b1;
                            b_act   = ACT_FLUSH_SLAVE;
                            f_c     = 1'b1;
                        end
                    end
                    HS_ACK_S2M: begin
                        if (m_active && r_m_wait) begin
                            if (i_sender != r_m_now) begin
                                n_m_now = i_sender;
                                f_b     = 1'b1;
                                b_act   = ACT_FLUSH_MASTER;
                                f_c     = 1'b1;
                            end
                            n_m_wait = 1'b0;
                            n_m_tmr  = rem_ack;
                            f_e      = (rem_ack == '0);
                        end
                    end
                    default: begin
                    end
                endcase
                rep_m = n_m_now;
                rep_s = n_s_now;
            end
            if (f_d) begin
                n_s_wait = 1'b1;
                n_s_at   = n_s_now;
                n_s_tmr  = win;
            end
            if (f_e) begin
                n_m_wait = 1'b1;
                n_m_at   = n_m_now;
                n_m_tmr  = win;
            end
        end
    end

    assign rep_en  = f_c && (!m_active || (rep_m != ID_UNK));
    assign rep_act = m_active ? ACT_REPORT_MSTR : ACT_REPORT_LOCAL;

    // results always fall in this order: reply, flush, report, slave ping, master ping
    always_comb begin
        cnt = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            s_act[i] = ACT_SEND_SLAVE;
            s_hs[i]  = HS_PING_M2S;
            s_rs[i]  = '0;
            s_rm[i]  = '0;
            s_rl[i]  = '0;
        end
        if (f_a) begin
            s_act[cnt[SLOT_W-1:0]] = a_act;
            s_hs[cnt[SLOT_W-1:0]]  = a_hs;
            cnt = cnt + RES_CNT_W'(1);
        end
        if (f_b) begin
            s_act[cnt[SLOT_W-1:0]] = b_act;
            cnt = cnt + RES_CNT_W'(1);
        end
        if (rep_en) begin
            s_act[cnt[SLOT_W-1:0]] = rep_act;
            s_rs[cnt[SLOT_W-1:0]]  = r_self;
            s_rm[cnt[SLOT_W-1:0]]  = rep_m;
            s_rl[cnt[SLOT_W-1:0]]  = rep_s;
            cnt = cnt + RES_CNT_W'(1);
        end
        if (f_d) begin
            s_act[cnt[SLOT_W-1:0]] = ACT_SEND_SLAVE;
            s_hs[cnt[SLOT_W-1:0]]  = HS_PING_M2S;
            cnt = cnt + RES_CNT_W'(1);
        end
        if (f_e) begin
            s_act[cnt[SLOT_W-1:0]] = ACT_SEND_MASTER;
            s_hs[cnt[SLOT_W-1:0]]  = HS_PING_S2M;
            cnt = cnt + RES_CNT_W'(1);
        end
    end

    always_comb begin
        o_bundle = '0;
        o_bundle[RES_CNT_W-1:0] = cnt;
        for (int i = 0; i < MAX_RES; i++) begin
            o_bundle[RES_CNT_W + i*RES_W +: RES_W] = {s_rl[i], s_rm[i], s_rs[i], s_hs[i], s_act[i]};
        end
    end

    assign o_push = accept && (cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self   <= '0;
            r_root   <= '0;
            r_ack_to <= DEFAULT_TIME;
            r_per    <= DEFAULT_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SELF_ID:     r_self   <= i_cfg_wdata[ID_BITS-1:0];
                CFG_ROOT_ID:     r_root   <= i_cfg_wdata[ID_BITS-1:0];
                CFG_ACK_TIMEOUT: r_ack_to <= i_cfg_wdata[CFG_TIME_W-1:0];
                CFG_PING_PERIOD: r_per    <= i_cfg_wdata[CFG_TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_now  <= ID_UNK;
            r_s_now  <= ID_UNK;
            r_m_at   <= ID_UNK;
            r_s_at   <= ID_UNK;
            r_m_wait <= 1'b0;
            r_s_wait <= 1'b0;
            r_m_tmr  <= '0;
            r_s_tmr  <= '0;
        end else begin
            r_m_now  <= n_m_now;
            r_s_now  <= n_s_now;
            r_m_at   <= n_m_at;
            r_s_at   <= n_s_at;
            r_m_wait <= n_m_wait;
            r_s_wait <= n_s_wait;
            r_m_tmr  <= n_m_tmr;
            r_s_tmr  <= n_s_tmr;
        end
    end

    a_tick_no_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_TICK)) |-> !f_b)
        else $error("tick produced a queue flush");

    a_root_master_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !m_active) |=> $stable(r_m_tmr))
        else $error("master side moved at root");

    a_ping_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_MSG) && ((i_hs == HS_PING_M2S) || (i_hs == HS_PING_S2M)))
        |-> (o_push && (s_act[0] == a_act)))
        else $error("incoming ping not acked first");

endmodule

// ===== hdl/nhl_back.sv =====
// ----------------------------------------------------------------------------
// nhl_back: result serializer
// Unpacks queued bundles and drives one result beat per cycle, while the
// output is ready, via an output register, marking each event's final result.
// ----------------------------------------------------------------------------
module nhl_back #(
    parameter int ID_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  logic [nhl_pkg::bundle_w(ID_BITS)-1:0] i_q_data,
    output logic                                  o_q_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [nhl_pkg::ACT_W-1:0]             o_action,
    output logic [nhl_pkg::HS_W-1:0]              o_hs,
    output logic signed [ID_BITS-1:0]             o_rep_self,
    output logic signed [ID_BITS-1:0]             o_rep_master,
    output logic signed [ID_BITS-1:0]             o_rep_slave,
    output logic                                  o_last
);
    import nhl_pkg::*;

    localparam int RES_W = res_w(ID_BITS);

    logic [SLOT_W-1:0]          r_idx;
    logic                       r_valid, r_last;
    t_action                    r_act;
    t_hs                        r_hs;
    logic signed [ID_BITS-1:0]  r_rs, r_rm, r_rl;

    logic [RES_W-1:0]           slot [MAX_RES];
    logic [RES_CNT_W-1:0]       cnt;
    logic                       load, is_last;

    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            slot[i] = i_q_data[RES_CNT_W + i*RES_W +: RES_W];
        end
    end

    assign cnt     = i_q_data[RES_CNT_W-1:0];
    assign load    = i_q_valid && (!r_valid || i_ready);
    assign is_last = ((RES_CNT_W'(r_idx) + RES_CNT_W'(1)) == cnt);
    assign o_q_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? '0 : r_idx + SLOT_W'(1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_act  <= slot[r_idx][ACT_W-1:0];
            r_hs   <= slot[r_idx][ACT_W +: HS_W];
            r_rs   <= slot[r_idx][ACT_W+HS_W +: ID_BITS];
            r_rm   <= slot[r_idx][ACT_W+HS_W+ID_BITS +: ID_BITS];
            r_rl   <= slot[r_idx][ACT_W+HS_W+2*ID_BITS +: ID_BITS];
            r_last <= is_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_action     = r_act;
    assign o_hs         = r_hs;
    assign o_rep_self   = r_rs;
    assign o_rep_master = r_rm;
    assign o_rep_slave  = r_rl;
    assign o_last       = r_last;

endmodule

// ===== hdl/neighbor_handshake_liveness.sv =====
// ----------------------------------------------------------------------------
// neighbor_handshake_liveness: chain neighbor tracking by ping and ack
// Front end, two-entry bundle queue and result serializer.
// ----------------------------------------------------------------------------
// An event (tick or received handshake) is accepted whenever the internal
// bundle queue has room, even while earlier results still wait at the
// output. Each event yields zero to three result beats, sent one per cycle by
// the single-beat output register while the output is ready. A tick that
// causes no result produces no beat.
module neighbor_handshake_liveness #(
    parameter int ID_BITS    = nhl_pkg::ID_BITS_DEF,
    parameter int TIMER_BITS = nhl_pkg::TIMER_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nhl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nhl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [((ID_BITS+7)/8)*8-1:0]      i_s_axis_tdata,   // peer_id
    input  logic [nhl_pkg::CMD_W+nhl_pkg::HS_W-1:0] i_s_axis_tuser, // cmd, hs_type
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [((3*ID_BITS+7)/8)*8-1:0]    o_m_axis_tdata,   // rep_self, rep_master, rep_slave
    output logic [nhl_pkg::ACT_W+nhl_pkg::HS_W-1:0] o_m_axis_tuser, // action, out_hs_type
    output logic                              o_m_axis_tlast
);
    import nhl_pkg::*;

    localparam int BUN_W = bundle_w(ID_BITS);
    localparam int OUT_W = ((3*ID_BITS+7)/8)*8;

    logic               q_push, q_full, q_valid, q_pop;
    logic [BUN_W-1:0]   f_bundle, q_data;
    t_action            b_act;
    t_hs                b_hs;
    logic signed [ID_BITS-1:0] b_rs, b_rm, b_rl;

    nhl_front #(
        .ID_BITS    (ID_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .i_cmd       (i_s_axis_tuser[0]),
        .i_hs        (i_s_axis_tuser[CMD_W +: HS_W]),
        .i_sender    (i_s_axis_tdata[ID_BITS-1:0]),
        .o_ready     (o_s_axis_tready),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_bundle    (f_bundle)
    );

    nhl_queue #(
        .WIDTH (BUN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_bundle),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    nhl_back #(
        .ID_BITS (ID_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_action     (b_act),
        .o_hs         (b_hs),
        .o_rep_self   (b_rs),
        .o_rep_master (b_rm),
        .o_rep_slave  (b_rl),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {b_hs, b_act};
    assign o_m_axis_tdata = OUT_W'({b_rl, b_rm, b_rs});

endmodule
